/* rtl/lanp_pkg.sv */
// ----------------------------------------------------------------------------
// lanp_pkg
// Shared types and constants of the level aware node pool.
// ----------------------------------------------------------------------------
package lanp_pkg;

  localparam int RANKS  = 256;
  localparam int DIMS   = 2;
  localparam int FACTOR = 3 ** DIMS;
  localparam int RANK_W = 8;
  localparam int CNT_W  = 9;
  localparam int LVL_W  = 4;
  localparam int BND_W  = 16;

  // request kinds
  localparam logic [3:0] KIND_REGISTER    = 4'd0;
  localparam logic [3:0] KIND_REMOVE      = 4'd1;
  localparam logic [3:0] KIND_SET_IDLE    = 4'd2;
  localparam logic [3:0] KIND_RESERVE_M   = 4'd3;
  localparam logic [3:0] KIND_RESERVE_R   = 4'd4;
  localparam logic [3:0] KIND_IS_REG      = 4'd5;
  localparam logic [3:0] KIND_IS_IDLE     = 4'd6;
  localparam logic [3:0] KIND_HAS_IDLE    = 4'd7;
  localparam logic [3:0] KIND_REMOVE_NEXT = 4'd8;

  // status codes
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_NONE  = 2'd1;
  localparam logic [1:0] STATUS_WRONG = 2'd2;

  // per-rank node states
  localparam logic [1:0] NODE_ABSENT = 2'd0;
  localparam logic [1:0] NODE_REG    = 2'd1;
  localparam logic [1:0] NODE_IDLE   = 2'd2;
  localparam logic [1:0] NODE_WORK   = 2'd3;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_READ,
    FSM_EXEC,
    FSM_SCAN,
    FSM_OUT
  } fsm_t;

  typedef struct packed {
    logic [3:0]        kind;
    logic [RANK_W-1:0] rank;
    logic              any_master;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [RANK_W-1:0] rank_out;
    logic              answer;
    logic [CNT_W-1:0]  node_count;
    logic [CNT_W-1:0]  idle_count;
  } rsp_t;

endpackage

/* rtl/lanp_ram.sv */
// ----------------------------------------------------------------------------
// lanp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lanp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/level_aware_node_pool_unit.sv */
// ----------------------------------------------------------------------------
// level_aware_node_pool_unit
// Pool of worker ranks with level-aware reservation and running counts.
// ----------------------------------------------------------------------------
// One request is handled at a time and one response comes back for each.
// Requests on a single rank (register, remove, set idle, reserve given and
// the two rank queries) pass through the read and execute states to the
// output state. Reserve for master, has idle for master and remove next
// walk the node state memory from rank 0, one read per cycle; the walk
// ends early at the first matching rank. The level of each rank is tracked
// alongside the walk by one shared boundary accumulator. The query for any
// registered node and unused kinds go straight to the output state. A
// finished response waits in the output register while the next request
// is taken.
module level_aware_node_pool_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  lanp_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output lanp_pkg::rsp_t rsp
);

  lanp_pkg::fsm_t state, state_next;
  lanp_pkg::req_t req_q, req_q_next;

  logic [lanp_pkg::CNT_W-1:0]  reg_total, reg_total_next;
  logic [lanp_pkg::CNT_W-1:0]  idle_total, idle_total_next;

  logic [lanp_pkg::CNT_W-1:0]  scan_idx, scan_idx_next;
  logic [lanp_pkg::LVL_W-1:0]  lvl, lvl_next;
  logic [lanp_pkg::BND_W-1:0]  bound, bound_next;
  logic [lanp_pkg::BND_W-1:0]  size, size_next;
  logic                        chk_pend, chk_pend_next;
  logic [lanp_pkg::RANK_W-1:0] chk_idx, chk_idx_next;
  logic [lanp_pkg::LVL_W-1:0]  chk_lvl, chk_lvl_next;
  logic [lanp_pkg::LVL_W-1:0]  tgt, tgt_next;

  logic [1:0]                  res_status, res_status_next;
  logic [lanp_pkg::RANK_W-1:0] res_rank, res_rank_next;
  logic                        res_answer, res_answer_next;

  logic [lanp_pkg::RANKS-1:0]  vld;
  logic                        rd_vld;
  logic                        mem_we;
  logic [lanp_pkg::RANK_W-1:0] waddr, raddr;
  logic [1:0]                  wdata, rdata;

  logic                        accept;
  logic                        rsp_free;
  logic [1:0]                  st;
  logic                        rank_valid;
  logic                        scan_kind;
  logic                        single_kind;
  logic                        start_scan;
  logic                        start_single;
  logic                        hit;
  logic                        scan_end;
  logic                        step_level;
  logic [lanp_pkg::LVL_W-1:0]  lvl_cur;

  lanp_ram #(
    .WIDTH(2),
    .DEPTH(lanp_pkg::RANKS)
  ) u_state_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign req_stall = (state != lanp_pkg::FSM_IDLE);
  assign accept    = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // a rank never written reads as absent
  assign st         = rd_vld ? rdata : lanp_pkg::NODE_ABSENT;
  assign rank_valid = (lanp_pkg::CNT_W'(req_q.rank) < lanp_pkg::CNT_W'(lanp_pkg::RANKS));

  assign scan_kind = (req.kind == lanp_pkg::KIND_RESERVE_M) ||
                     (req.kind == lanp_pkg::KIND_REMOVE_NEXT) ||
                     ((req.kind == lanp_pkg::KIND_HAS_IDLE) && !req.any_master);
  assign single_kind = (req.kind == lanp_pkg::KIND_REGISTER) ||
                       (req.kind == lanp_pkg::KIND_REMOVE) ||
                       (req.kind == lanp_pkg::KIND_SET_IDLE) ||
                       (req.kind == lanp_pkg::KIND_RESERVE_R) ||
                       (req.kind == lanp_pkg::KIND_IS_REG) ||
                       (req.kind == lanp_pkg::KIND_IS_IDLE);
  assign start_scan   = accept && scan_kind;
  assign start_single = accept && single_kind;

  // level of the rank being issued: crossing the group boundary opens the next level
  assign step_level = (lanp_pkg::BND_W'(scan_idx) > bound);
  assign lvl_cur    = step_level ? lvl + 1'b1 : lvl;

  always_comb begin
    hit = 1'b0;
    if (chk_pend) begin
      if (req_q.kind == lanp_pkg::KIND_REMOVE_NEXT) begin
        hit = (st != lanp_pkg::NODE_ABSENT);
      end else begin
        hit = (chk_idx > req_q.rank) && (st == lanp_pkg::NODE_IDLE) && (chk_lvl == tgt);
      end
    end
  end

  assign scan_end = (scan_idx == lanp_pkg::CNT_W'(lanp_pkg::RANKS)) && !chk_pend;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lanp_pkg::FSM_IDLE: begin
        if (start_scan) begin
          state_next = lanp_pkg::FSM_SCAN;
        end else if (start_single) begin
          state_next = lanp_pkg::FSM_READ;
        end else if (accept) begin
          state_next = lanp_pkg::FSM_OUT;
        end
      end
      lanp_pkg::FSM_READ: state_next = lanp_pkg::FSM_EXEC;
      lanp_pkg::FSM_EXEC: state_next = lanp_pkg::FSM_OUT;
      lanp_pkg::FSM_SCAN: begin
        if (hit || scan_end) begin
          state_next = lanp_pkg::FSM_OUT;
        end
      end
      lanp_pkg::FSM_OUT: begin
        if (rsp_free) begin
          state_next = lanp_pkg::FSM_IDLE;
        end
      end
      default: state_next = lanp_pkg::FSM_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_q_next      = req_q;
    reg_total_next  = reg_total;
    idle_total_next = idle_total;
    scan_idx_next   = scan_idx;
    lvl_next        = lvl;
    bound_next      = bound;
    size_next       = size;
    chk_pend_next   = chk_pend;
    chk_idx_next    = chk_idx;
    chk_lvl_next    = chk_lvl;
    tgt_next        = tgt;
    res_status_next = res_status;
    res_rank_next   = res_rank;
    res_answer_next = res_answer;
    mem_we          = 1'b0;
    waddr           = req_q.rank;
    wdata           = lanp_pkg::NODE_ABSENT;
    raddr           = req_q.rank;

    case (state)
      lanp_pkg::FSM_IDLE: begin
        if (accept) begin
          req_q_next      = req;
          scan_idx_next   = '0;
          lvl_next        = '0;
          bound_next      = '0;
          size_next       = lanp_pkg::BND_W'(1);
          chk_pend_next   = 1'b0;
          tgt_next        = '0;
          res_status_next = lanp_pkg::STATUS_DONE;
          res_rank_next   = '0;
          res_answer_next = (req.kind == lanp_pkg::KIND_HAS_IDLE) && req.any_master &&
                            (reg_total != '0);
        end
      end

      lanp_pkg::FSM_READ: begin
        raddr = req_q.rank;
      end

      lanp_pkg::FSM_EXEC: begin
        case (req_q.kind)
          lanp_pkg::KIND_REGISTER: begin
            if (!rank_valid || st != lanp_pkg::NODE_ABSENT) begin
              res_status_next = lanp_pkg::STATUS_WRONG;
            end else begin
              mem_we         = 1'b1;
              wdata          = lanp_pkg::NODE_REG;
              reg_total_next = reg_total + 1'b1;
            end
          end
          lanp_pkg::KIND_REMOVE: begin
            if (st == lanp_pkg::NODE_ABSENT) begin
              res_status_next = lanp_pkg::STATUS_WRONG;
            end else begin
              if (st == lanp_pkg::NODE_IDLE) begin
                idle_total_next = idle_total - 1'b1;
              end
              mem_we         = 1'b1;
              wdata          = lanp_pkg::NODE_ABSENT;
              reg_total_next = reg_total - 1'b1;
            end
          end
          lanp_pkg::KIND_SET_IDLE: begin
            if (st == lanp_pkg::NODE_ABSENT) begin
              res_status_next = lanp_pkg::STATUS_WRONG;
            end else if (st != lanp_pkg::NODE_IDLE) begin
              mem_we          = 1'b1;
              wdata           = lanp_pkg::NODE_IDLE;
              idle_total_next = idle_total + 1'b1;
            end
          end
          lanp_pkg::KIND_RESERVE_R: begin
            if (st != lanp_pkg::NODE_IDLE) begin
              res_status_next = lanp_pkg::STATUS_WRONG;
            end else begin
              mem_we          = 1'b1;
              wdata           = lanp_pkg::NODE_WORK;
              idle_total_next = idle_total - 1'b1;
            end
          end
          lanp_pkg::KIND_IS_REG:  res_answer_next = (st != lanp_pkg::NODE_ABSENT);
          lanp_pkg::KIND_IS_IDLE: res_answer_next = (st == lanp_pkg::NODE_IDLE);
          default: ;
        endcase
      end

      lanp_pkg::FSM_SCAN: begin
        // issue side: one read per cycle with the level of that rank
        raddr = scan_idx[lanp_pkg::RANK_W-1:0];
        if (scan_idx < lanp_pkg::CNT_W'(lanp_pkg::RANKS)) begin
          chk_pend_next = 1'b1;
          chk_idx_next  = scan_idx[lanp_pkg::RANK_W-1:0];
          chk_lvl_next  = lvl_cur;
          scan_idx_next = scan_idx + 1'b1;
          if (step_level) begin
            lvl_next   = lvl_cur;
            bound_next = bound + size;
            size_next  = lanp_pkg::BND_W'(size * lanp_pkg::BND_W'(lanp_pkg::FACTOR));
          end
        end else begin
          chk_pend_next = 1'b0;
        end

        // check side: data of the previous read
        if (chk_pend && chk_idx == req_q.rank) begin
          tgt_next = chk_lvl + 1'b1;
        end
        if (hit) begin
          waddr = chk_idx;
          case (req_q.kind)
            lanp_pkg::KIND_RESERVE_M: begin
              mem_we          = 1'b1;
              wdata           = lanp_pkg::NODE_WORK;
              idle_total_next = idle_total - 1'b1;
              res_rank_next   = chk_idx;
            end
            lanp_pkg::KIND_REMOVE_NEXT: begin
              mem_we         = 1'b1;
              wdata          = lanp_pkg::NODE_ABSENT;
              reg_total_next = reg_total - 1'b1;
              if (st == lanp_pkg::NODE_IDLE) begin
                idle_total_next = idle_total - 1'b1;
              end
              res_rank_next = chk_idx;
            end
            default: res_answer_next = 1'b1;
          endcase
        end else if (scan_end) begin
          if (req_q.kind != lanp_pkg::KIND_HAS_IDLE) begin
            res_status_next = lanp_pkg::STATUS_NONE;
          end
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lanp_pkg::FSM_IDLE;
      reg_total  <= '0;
      idle_total <= '0;
      vld        <= '0;
      rsp_valid  <= 1'b0;
      chk_pend   <= 1'b0;
    end else begin
      state      <= state_next;
      reg_total  <= reg_total_next;
      idle_total <= idle_total_next;
      chk_pend   <= chk_pend_next;
      if (mem_we) begin
        vld[waddr] <= 1'b1;
      end
      if (state == lanp_pkg::FSM_OUT && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_q      <= req_q_next;
    scan_idx   <= scan_idx_next;
    lvl        <= lvl_next;
    bound      <= bound_next;
    size       <= size_next;
    chk_idx    <= chk_idx_next;
    chk_lvl    <= chk_lvl_next;
    tgt        <= tgt_next;
    res_status <= res_status_next;
    res_rank   <= res_rank_next;
    res_answer <= res_answer_next;
    rd_vld     <= vld[raddr];
    if (state == lanp_pkg::FSM_OUT && rsp_free) begin
      rsp.status     <= res_status;
      rsp.rank_out   <= res_rank;
      rsp.answer     <= res_answer;
      rsp.node_count <= reg_total;
      rsp.idle_count <= idle_total;
    end
  end

endmodule
